/* sv/usb_audio_feature_unit_gain_defines.svh */
// assertion macros for the usb audio feature unit gain block
// included by the top level, no other dependencies
`ifndef USB_AUDIO_FEATURE_UNIT_GAIN_DEFINES_SVH
`define USB_AUDIO_FEATURE_UNIT_GAIN_DEFINES_SVH

// same-cycle implication
`define UAFG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uafg implication check failed");

// next-cycle implication
`define UAFG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uafg next-cycle check failed");

`endif

/* sv/uafg_pkg.sv */
// shared types and constants for the usb audio feature unit gain block
// no dependencies
package uafg_pkg;

  // op codes carried on s_tuser
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // uac2 request, entity and selector codes
  localparam logic [7:0] REQ_CUR      = 8'd1;
  localparam logic [7:0] ENT_FEATURE  = 8'd2;
  localparam logic [7:0] ENT_CLOCK    = 8'd4;
  localparam logic [7:0] CS_MUTE      = 8'd1;
  localparam logic [7:0] CS_VOLUME    = 8'd2;
  localparam logic [7:0] CS_SAM_FREQ  = 8'd1;
  localparam logic [7:0] CS_CLK_VALID = 8'd2;

  localparam logic [15:0] LEN_MUTE   = 16'd1;
  localparam logic [15:0] LEN_VOLUME = 16'd2;
  localparam logic [15:0] LEN_RATE   = 16'd4;

  localparam logic [31:0] SAMPLE_RATE = 32'd48000;
  localparam logic signed [15:0] VOL_MIN = -16'sd15360;
  localparam logic signed [15:0] VOL_MAX = 16'sd0;
  localparam logic [15:0] UNITY_GAIN = 16'h8000;

  // fixed point exponential, q62 with 1.0 = 2^62
  localparam logic [63:0] Q_ONE     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] LN10_STEP = 64'd2073984273359369;
  localparam int unsigned DB_STEP   = 5120;
  localparam int unsigned DIVISOR_W = 5;
  localparam logic [DIVISOR_W-1:0] SERIES_TERMS = 5'd24;
  // floor(x / 10) = (x * RECIP_TEN) >> 67 for any 64-bit x
  localparam logic [63:0] RECIP_TEN = 64'hCCCC_CCCC_CCCC_CCCD;

  typedef struct packed {
    logic start;
    logic div;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

endpackage

/* sv/uafg_alu.sv */
// shared arithmetic unit: 64x64 multiply in four 32x32 steps,
// or 64-bit by small divisor restoring divide one bit per cycle
// depends on uafg_pkg
module uafg_alu (
  input  logic               clk,
  input  logic               rst,
  input  uafg_pkg::alu_req_t req,
  input  logic [63:0]        a,
  input  logic [63:0]        b,
  output uafg_pkg::alu_rsp_t rsp,
  output logic [127:0]       prod,
  output logic [63:0]        quo
);

  logic                             busy;
  logic                             done;
  logic                             div_mode;
  logic [5:0]                       cnt;
  logic [63:0]                      opa;
  logic [63:0]                      opb;
  logic [127:0]                     acc;
  logic [63:0]                      quo_r;
  logic [uafg_pkg::DIVISOR_W-1:0]   rem;

  logic [31:0]                      a_part;
  logic [31:0]                      b_part;
  logic [63:0]                      pp;
  logic [127:0]                     pp_sh;
  logic [uafg_pkg::DIVISOR_W:0]     rem_sh;
  logic [uafg_pkg::DIVISOR_W:0]     divisor;
  logic                             ge;
  logic                             last;

  assign a_part  = cnt[0] ? opa[63:32] : opa[31:0];
  assign b_part  = cnt[1] ? opb[63:32] : opb[31:0];
  assign pp      = a_part * b_part;
  assign rem_sh  = {rem, quo_r[63]};
  assign divisor = {1'b0, opb[uafg_pkg::DIVISOR_W-1:0]};
  assign ge      = rem_sh >= divisor;
  assign last    = div_mode ? (cnt == 6'd63) : (cnt == 6'd3);

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      2'd2:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_mode <= req.div;
      cnt      <= 6'd0;
      opa      <= a;
      opb      <= b;
      acc      <= 128'd0;
      quo_r    <= a;
      rem      <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (div_mode) begin
        rem   <= ge ? uafg_pkg::DIVISOR_W'(rem_sh - divisor)
                    : rem_sh[uafg_pkg::DIVISOR_W-1:0];
        quo_r <= {quo_r[62:0], ge};
      end else begin
        acc <= acc + pp_sh;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign prod     = acc;
  assign quo      = quo_r;

endmodule

/* sv/usb_audio_feature_unit_gain.sv */
// usb audio class 2 microphone feature unit: mute, volume, clock queries
// and q1.15 gain on the sample stream; depends on uafg_pkg, uafg_alu and
// usb_audio_feature_unit_gain_defines.svh
//
// channel  dir  handshake           tdata / tuser
// s_*      in   s_tvalid/s_tready   request or sample, op on s_tuser
// m_*      out  m_tvalid/m_tready   accepted, read_value, sample_out
//
// unmuted samples pass through the shared multiplier; a volume set recomputes
// the gain on the shared unit, q counting the total attenuation in whole 20 dB
// steps; the 64-bit divider for the series terms gives one quotient bit per cycle
// one request at a time; a finished result may wait in the output register
// while the next request is taken; rst is synchronous and restores unity gain
`include "usb_audio_feature_unit_gain_defines.svh"

module usb_audio_feature_unit_gain #(
  parameter int CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // request_code, entity_id, control_selector, channel_number,
  // request_length, payload, sample_in
  input  logic [95:0] s_tdata,
  // op
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // accepted, read_value, sample_out, zero fill
  output logic [55:0] m_tdata
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W = 16 + CH_W;
  localparam int Q_W   = $clog2(3 * CHANNELS + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SUM   = 4'd1;
  localparam logic [3:0] ST_QDIV  = 4'd2;
  localparam logic [3:0] ST_YMUL  = 4'd3;
  localparam logic [3:0] ST_TMUL  = 4'd4;
  localparam logic [3:0] ST_TDIV  = 4'd5;
  localparam logic [3:0] ST_SQ    = 4'd6;
  localparam logic [3:0] ST_DIV10 = 4'd7;
  localparam logic [3:0] ST_SMUL  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  // request fields
  logic [1:0]  op;
  logic [7:0]  request_code;
  logic [7:0]  entity_id;
  logic [7:0]  control_selector;
  logic [7:0]  channel_number;
  logic [15:0] request_length;
  logic [31:0] payload;
  logic [15:0] sample_in;

  assign op               = s_tuser;
  assign request_code     = s_tdata[7:0];
  assign entity_id        = s_tdata[15:8];
  assign control_selector = s_tdata[23:16];
  assign channel_number   = s_tdata[31:24];
  assign request_length   = s_tdata[47:32];
  assign payload          = s_tdata[79:48];
  assign sample_in        = s_tdata[95:80];

  logic [3:0]           state;
  logic [CHANNELS-1:0]  mute;
  logic [15:0]          vol [CHANNELS];
  logic [15:0]          gain;
  logic                 res_ok;
  logic [31:0]          res_rd;
  logic [15:0]          res_so;
  logic [CH_W-1:0]      idx;
  logic [SUM_W-1:0]     t;
  logic [Q_W-1:0]       q;
  logic [63:0]          y;
  logic [63:0]          series;
  logic [uafg_pkg::DIVISOR_W-1:0] n;
  logic [1:0]           sq_cnt;
  logic                 smp_neg;

  uafg_pkg::alu_req_t   alu_req;
  uafg_pkg::alu_rsp_t   alu_rsp;
  logic [63:0]          alu_a;
  logic [63:0]          alu_b;
  logic [127:0]         prod;
  logic [63:0]          quo;

  uafg_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .a    (alu_a),
    .b    (alu_b),
    .rsp  (alu_rsp),
    .prod (prod),
    .quo  (quo)
  );

  // decode
  logic            accept;
  logic            ch_ok;
  logic            is_cur;
  logic [CH_W-1:0] ch_idx;
  logic [CH_W-1:0] rd_idx;
  logic [15:0]     vol_rd;
  logic [15:0]     vol_neg;
  logic            vol_ok;
  logic            d_ok;
  logic [31:0]     d_rd;
  logic            d_mute_wr;
  logic            d_vol_wr;
  logic [16:0]     smp_ext;
  logic [16:0]     smp_mag;
  logic [16:0]     out_mag;
  logic [63:0]     series_next;
  logic [63:0]     qres;
  logic [63:0]     tenth;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign ch_ok    = channel_number < 8'(CHANNELS);
  assign is_cur   = request_code == uafg_pkg::REQ_CUR;
  assign ch_idx   = channel_number[CH_W-1:0];
  assign rd_idx   = (state == ST_SUM) ? idx : ch_idx;
  assign vol_rd   = vol[rd_idx];
  assign vol_neg  = 16'(17'd0 - {vol_rd[15], vol_rd});
  assign vol_ok   = ($signed(payload[15:0]) <= uafg_pkg::VOL_MAX) &&
                    ($signed(payload[15:0]) >= uafg_pkg::VOL_MIN);
  assign smp_ext  = {sample_in[15], sample_in};
  assign smp_mag  = sample_in[15] ? (17'd0 - smp_ext) : smp_ext;
  assign out_mag  = prod[31:15];
  assign qres     = prod[125:62];
  assign tenth    = {3'd0, prod[127:67]};
  assign series_next = n[0] ? (series - quo) : (series + quo);

  always_comb begin
    d_ok      = 1'b0;
    d_rd      = 32'd0;
    d_mute_wr = 1'b0;
    d_vol_wr  = 1'b0;
    unique case (op)
      uafg_pkg::OP_SET: begin
        if (is_cur && ch_ok) begin
          priority if (entity_id == uafg_pkg::ENT_FEATURE &&
                       control_selector == uafg_pkg::CS_MUTE &&
                       request_length == uafg_pkg::LEN_MUTE) begin
            d_mute_wr = 1'b1;
            d_ok      = 1'b1;
          end else if (entity_id == uafg_pkg::ENT_FEATURE &&
                       control_selector == uafg_pkg::CS_VOLUME &&
                       request_length == uafg_pkg::LEN_VOLUME) begin
            d_vol_wr = vol_ok;
            d_ok     = vol_ok;
          end else if (entity_id == uafg_pkg::ENT_CLOCK &&
                       control_selector == uafg_pkg::CS_SAM_FREQ &&
                       request_length == uafg_pkg::LEN_RATE) begin
            d_ok = payload == uafg_pkg::SAMPLE_RATE;
          end else begin
            d_ok = 1'b0;
          end
        end
      end
      uafg_pkg::OP_GET: begin
        if (ch_ok) begin
          priority if (entity_id == uafg_pkg::ENT_CLOCK &&
                       control_selector == uafg_pkg::CS_SAM_FREQ) begin
            d_ok = is_cur;
            d_rd = is_cur ? uafg_pkg::SAMPLE_RATE : 32'd0;
          end else if (entity_id == uafg_pkg::ENT_CLOCK &&
                       control_selector == uafg_pkg::CS_CLK_VALID) begin
            d_ok = 1'b1;
            d_rd = 32'd1;
          end else if (entity_id == uafg_pkg::ENT_FEATURE &&
                       control_selector == uafg_pkg::CS_MUTE) begin
            d_ok = 1'b1;
            d_rd = 32'(mute[ch_idx]);
          end else if (entity_id == uafg_pkg::ENT_FEATURE &&
                       control_selector == uafg_pkg::CS_VOLUME) begin
            d_ok = is_cur;
            d_rd = is_cur ? 32'(vol_rd) : 32'd0;
          end else begin
            d_ok = 1'b0;
          end
        end
      end
      uafg_pkg::OP_SAMPLE: begin
        d_ok = 1'b1;
      end
      default: begin
        d_ok = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      mute          <= '0;
      gain          <= uafg_pkg::UNITY_GAIN;
      alu_req.start <= 1'b0;
      alu_req.div   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        vol[i] <= 16'd0;
      end
    end else begin
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          alu_req.start <= accept && op == uafg_pkg::OP_SAMPLE && mute == '0;
          if (accept) begin
            res_ok <= d_ok;
            res_rd <= d_rd;
            res_so <= 16'd0;
            if (d_mute_wr) begin
              mute[ch_idx] <= payload[7:0] != 8'd0;
            end
            if (d_vol_wr) begin
              vol[ch_idx] <= payload[15:0];
              t           <= '0;
              q           <= '0;
              idx         <= '0;
              state       <= ST_SUM;
            end else if (op == uafg_pkg::OP_SAMPLE && mute == '0) begin
              smp_neg     <= sample_in[15];
              alu_a       <= 64'(smp_mag);
              alu_b       <= 64'(gain);
              alu_req.div <= 1'b0;
              state       <= ST_SMUL;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_SUM: begin
          alu_req.start <= 1'b0;
          t <= t + SUM_W'(vol_neg);
          if (idx == CH_W'(CHANNELS - 1)) begin
            state <= ST_QDIV;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_QDIV: begin
          alu_req.start <= t < SUM_W'(uafg_pkg::DB_STEP);
          if (t >= SUM_W'(uafg_pkg::DB_STEP)) begin
            t <= t - SUM_W'(uafg_pkg::DB_STEP);
            q <= q + 1'b1;
          end else begin
            alu_a       <= 64'(t[12:0]);
            alu_b       <= uafg_pkg::LN10_STEP;
            alu_req.div <= 1'b0;
            state       <= ST_YMUL;
          end
        end
        ST_YMUL: begin
          alu_req.start <= alu_rsp.done;
          if (alu_rsp.done) begin
            y           <= prod[66:3];
            series      <= uafg_pkg::Q_ONE;
            n           <= uafg_pkg::DIVISOR_W'(1);
            alu_a       <= uafg_pkg::Q_ONE;
            alu_b       <= prod[66:3];
            alu_req.div <= 1'b0;
            state       <= ST_TMUL;
          end
        end
        ST_TMUL: begin
          alu_req.start <= alu_rsp.done;
          if (alu_rsp.done) begin
            alu_a       <= qres;
            alu_b       <= 64'(n);
            alu_req.div <= 1'b1;
            state       <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          alu_req.start <= alu_rsp.done;
          if (alu_rsp.done) begin
            series      <= series_next;
            alu_req.div <= 1'b0;
            if (n == uafg_pkg::SERIES_TERMS) begin
              alu_a  <= series_next;
              alu_b  <= series_next;
              sq_cnt <= 2'd0;
              state  <= ST_SQ;
            end else begin
              n     <= n + 1'b1;
              alu_a <= quo;
              alu_b <= y;
              state <= ST_TMUL;
            end
          end
        end
        ST_SQ: begin
          alu_req.start <= alu_rsp.done && !(sq_cnt == 2'd2 && q == '0);
          if (alu_rsp.done) begin
            if (sq_cnt == 2'd2) begin
              if (q == '0) begin
                gain  <= prod[124:109];
                state <= ST_FIN;
              end else begin
                alu_a       <= qres;
                alu_b       <= uafg_pkg::RECIP_TEN;
                alu_req.div <= 1'b0;
                state       <= ST_DIV10;
              end
            end else begin
              sq_cnt      <= sq_cnt + 2'd1;
              alu_a       <= qres;
              alu_b       <= qres;
              alu_req.div <= 1'b0;
            end
          end
        end
        ST_DIV10: begin
          alu_req.start <= alu_rsp.done && q != Q_W'(1);
          if (alu_rsp.done) begin
            q <= q - 1'b1;
            if (q == Q_W'(1)) begin
              gain  <= tenth[62:47];
              state <= ST_FIN;
            end else begin
              alu_a       <= tenth;
              alu_b       <= uafg_pkg::RECIP_TEN;
              alu_req.div <= 1'b0;
            end
          end
        end
        ST_SMUL: begin
          alu_req.start <= 1'b0;
          if (alu_rsp.done) begin
            res_so <= smp_neg ? 16'(17'd0 - out_mag) : out_mag[15:0];
            state  <= ST_FIN;
          end
        end
        ST_FIN: begin
          alu_req.start <= 1'b0;
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          alu_req.start <= 1'b0;
          state         <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      m_tdata <= {7'd0, res_so, res_rd, res_ok};
    end
  end

  `UAFG_ASSERT_IMPLY(a_reject_no_data, clk, rst, m_tvalid && !m_tdata[0], m_tdata[32:1] == 32'd0)
  `UAFG_ASSERT_IMPLY(a_gain_range, clk, rst, 1'b1, gain <= uafg_pkg::UNITY_GAIN)
  `UAFG_ASSERT_IMPLY(a_alu_start_idle, clk, rst, alu_req.start, !alu_rsp.busy)
  `UAFG_ASSERT_NEXT(a_one_request, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

/* test/testbench.sv */
// self-checking bench for usb_audio_feature_unit_gain: mute, volume, clock requests and samples
// predicts every reply in place and checks the m_* stream in order
// depends on uafg_pkg and the usb_audio_feature_unit_gain top level
`timescale 1ns / 100ps

module testbench;

  localparam int CHANNELS = 2;
  localparam logic [1:0] OP_UNDEF = 2'd3;

  // request fields, request_code in the lowest bits
  typedef struct packed {
    logic [15:0] sample_in;
    logic [31:0] payload;
    logic [15:0] length;
    logic [7:0]  channel;
    logic [7:0]  selector;
    logic [7:0]  entity;
    logic [7:0]  request;
  } req_t;

  // reply fields, accepted in the lowest bit
  typedef struct packed {
    logic [15:0] sample_out;
    logic [31:0] read_value;
    logic        accepted;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  logic        src_gaps = 1'b1;
  logic        sink_gaps = 1'b1;
  logic        long_hold = 1'b0;
  int          sink_idle_left = 0;
  int          mismatches = 0;

  reply_t      reply_q[$];

  logic        mute_state[CHANNELS];
  logic [15:0] volume_state[CHANNELS];
  logic [31:0] gain_state;

  usb_audio_feature_unit_gain #(.CHANNELS(CHANNELS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // q62 product, floored
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // q1.15 gain for a total volume s in 1/256 dB
  function automatic logic [31:0] gain_for_sum(input int s);
    int unsigned t, q;
    logic [63:0] rem, y, acc, term, e;
    t = (s < 0) ? -s : 0;
    q = t / uafg_pkg::DB_STEP;
    rem = 64'(t % uafg_pkg::DB_STEP);
    y = (rem * uafg_pkg::LN10_STEP) >> 3;
    acc = uafg_pkg::Q_ONE;
    term = uafg_pkg::Q_ONE;
    for (int n = 1; n <= 24; n++) begin
      term = q62_mul(term, y) / n;
      if (n % 2) acc = acc - term;
      else acc = acc + term;
    end
    e = q62_mul(acc, acc);
    e = q62_mul(e, e);
    e = q62_mul(e, e);
    repeat (q) e = e / 10;
    return 32'(e >> 47);
  endfunction

  function automatic reply_t predict_reply(input logic [1:0] op, input req_t r);
    reply_t res;
    logic signed [15:0] v;
    int sum, smp, scaled;
    logic ch;
    res = '0;
    ch = r.channel[0];
    case (op)
      uafg_pkg::OP_SET: begin
        if (r.request == uafg_pkg::REQ_CUR && r.channel < CHANNELS) begin
          if (r.entity == uafg_pkg::ENT_FEATURE && r.selector == uafg_pkg::CS_MUTE &&
              r.length == uafg_pkg::LEN_MUTE) begin
            mute_state[ch] = (r.payload[7:0] != 8'd0);
            res.accepted = 1'b1;
          end else if (r.entity == uafg_pkg::ENT_FEATURE && r.selector == uafg_pkg::CS_VOLUME &&
                       r.length == uafg_pkg::LEN_VOLUME) begin
            v = r.payload[15:0];
            if (v <= uafg_pkg::VOL_MAX && v >= uafg_pkg::VOL_MIN) begin
              volume_state[ch] = r.payload[15:0];
              sum = $signed(volume_state[0]);
              sum += $signed(volume_state[1]);
              gain_state = gain_for_sum(sum);
              res.accepted = 1'b1;
            end
          end else if (r.entity == uafg_pkg::ENT_CLOCK && r.selector == uafg_pkg::CS_SAM_FREQ &&
                       r.length == uafg_pkg::LEN_RATE) begin
            res.accepted = (r.payload == uafg_pkg::SAMPLE_RATE);
          end
        end
      end
      uafg_pkg::OP_GET: begin
        if (r.channel < CHANNELS) begin
          if (r.entity == uafg_pkg::ENT_CLOCK && r.selector == uafg_pkg::CS_SAM_FREQ) begin
            if (r.request == uafg_pkg::REQ_CUR) begin
              res.accepted = 1'b1;
              res.read_value = uafg_pkg::SAMPLE_RATE;
            end
          end else if (r.entity == uafg_pkg::ENT_CLOCK &&
                       r.selector == uafg_pkg::CS_CLK_VALID) begin
            res.accepted = 1'b1;
            res.read_value = 32'd1;
          end else if (r.entity == uafg_pkg::ENT_FEATURE && r.selector == uafg_pkg::CS_MUTE) begin
            res.accepted = 1'b1;
            res.read_value = {31'd0, mute_state[ch]};
          end else if (r.entity == uafg_pkg::ENT_FEATURE &&
                       r.selector == uafg_pkg::CS_VOLUME) begin
            if (r.request == uafg_pkg::REQ_CUR) begin
              res.accepted = 1'b1;
              res.read_value = {16'd0, volume_state[ch]};
            end
          end
        end
      end
      uafg_pkg::OP_SAMPLE: begin
        res.accepted = 1'b1;
        if (!(mute_state[0] || mute_state[1])) begin
          smp = $signed(r.sample_in);
          scaled = smp * int'(gain_state) / 32768;
          res.sample_out = scaled[15:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t mk(input logic [7:0] req, input logic [7:0] ent,
                              input logic [7:0] sel, input logic [7:0] ch,
                              input logic [15:0] len, input logic [31:0] pay,
                              input logic [15:0] smp);
    req_t r;
    r.request = req;
    r.entity = ent;
    r.selector = sel;
    r.channel = ch;
    r.length = len;
    r.payload = pay;
    r.sample_in = smp;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] op, input req_t r);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= r;
    do @(posedge clk); while (!s_tready);
    reply_q.push_back(predict_reply(op, r));
  endtask

  task automatic set_cur(input logic [7:0] ent, input logic [7:0] sel, input logic [7:0] ch,
                         input logic [15:0] len, input logic [31:0] pay);
    send_item(uafg_pkg::OP_SET, mk(uafg_pkg::REQ_CUR, ent, sel, ch, len, pay, 16'd0));
  endtask

  task automatic get_req(input logic [7:0] req, input logic [7:0] ent,
                         input logic [7:0] sel, input logic [7:0] ch);
    send_item(uafg_pkg::OP_GET, mk(req, ent, sel, ch, 16'd0, 32'd0, 16'd0));
  endtask

  task automatic play(input logic [15:0] smp);
    send_item(uafg_pkg::OP_SAMPLE, mk(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 32'd0, smp));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed requests with random content, some broken ones and noise
  task automatic random_item(output logic [1:0] op, output req_t r);
    int pick, tgt;
    r = req_t'({$urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      op = uafg_pkg::OP_SAMPLE;
      if ($urandom_range(0, 19) == 0) r.sample_in = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    end else if (pick < 75) begin
      op = uafg_pkg::OP_SET;
      r.request = uafg_pkg::REQ_CUR;
      r.channel = 8'($urandom_range(0, CHANNELS - 1));
      tgt = $urandom_range(0, 9);
      if (tgt < 4) begin
        r.entity = uafg_pkg::ENT_FEATURE;
        r.selector = uafg_pkg::CS_MUTE;
        r.length = uafg_pkg::LEN_MUTE;
        if ($urandom_range(0, 9) < 8) r.payload[7:0] = 8'd0;
      end else if (tgt < 7) begin
        r.entity = uafg_pkg::ENT_FEATURE;
        r.selector = uafg_pkg::CS_VOLUME;
        r.length = uafg_pkg::LEN_VOLUME;
        if ($urandom_range(0, 9) < 8) r.payload[15:0] = 16'(0 - $urandom_range(0, 15360));
      end else begin
        r.entity = uafg_pkg::ENT_CLOCK;
        r.selector = uafg_pkg::CS_SAM_FREQ;
        r.length = uafg_pkg::LEN_RATE;
        if ($urandom_range(0, 1)) r.payload = uafg_pkg::SAMPLE_RATE;
      end
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 4))
          0: r.request = 8'($urandom);
          1: r.entity = 8'($urandom);
          2: r.selector = 8'($urandom);
          3: r.channel = 8'($urandom);
          default: r.length = 16'($urandom);
        endcase
      end
    end else if (pick < 95) begin
      op = uafg_pkg::OP_GET;
      case ($urandom_range(0, 3))
        0: begin r.entity = uafg_pkg::ENT_CLOCK; r.selector = uafg_pkg::CS_SAM_FREQ; end
        1: begin r.entity = uafg_pkg::ENT_CLOCK; r.selector = uafg_pkg::CS_CLK_VALID; end
        2: begin r.entity = uafg_pkg::ENT_FEATURE; r.selector = uafg_pkg::CS_MUTE; end
        default: begin r.entity = uafg_pkg::ENT_FEATURE; r.selector = uafg_pkg::CS_VOLUME; end
      endcase
      if ($urandom_range(0, 6) != 0) r.request = uafg_pkg::REQ_CUR;
      if ($urandom_range(0, 9) != 0) r.channel = 8'($urandom_range(0, CHANNELS - 1));
      if ($urandom_range(0, 9) == 0) r.entity = 8'($urandom);
    end else begin
      op = OP_UNDEF;
    end
  endtask

  task automatic test_defaults();
    get_req(uafg_pkg::REQ_CUR, uafg_pkg::ENT_CLOCK, uafg_pkg::CS_SAM_FREQ, 8'd0);
    get_req(8'hff, uafg_pkg::ENT_CLOCK, uafg_pkg::CS_CLK_VALID, 8'd1);
    get_req(uafg_pkg::REQ_CUR, uafg_pkg::ENT_FEATURE, uafg_pkg::CS_VOLUME, 8'd1);
    play(16'h7fff);
    play(16'h8000);
  endtask

  task automatic test_mute();
    set_cur(uafg_pkg::ENT_FEATURE, uafg_pkg::CS_MUTE, 8'd0, uafg_pkg::LEN_MUTE, 32'hffff_ffff);
    play(16'h8000);
    get_req(8'd0, uafg_pkg::ENT_FEATURE, uafg_pkg::CS_MUTE, 8'd0);
    // only the low byte counts, so this unmutes
    set_cur(uafg_pkg::ENT_FEATURE, uafg_pkg::CS_MUTE, 8'd0, uafg_pkg::LEN_MUTE, 32'h0000_0100);
  endtask

  task automatic test_volume();
    set_cur(uafg_pkg::ENT_FEATURE, uafg_pkg::CS_VOLUME, 8'd0, uafg_pkg::LEN_VOLUME,
            {16'd0, uafg_pkg::VOL_MIN});
    set_cur(uafg_pkg::ENT_FEATURE, uafg_pkg::CS_VOLUME, 8'd1, uafg_pkg::LEN_VOLUME,
            {16'hffff, uafg_pkg::VOL_MIN});
    play(16'h7fff);
    get_req(uafg_pkg::REQ_CUR, uafg_pkg::ENT_FEATURE, uafg_pkg::CS_VOLUME, 8'd0);
    // just above 0 dB and just below -60 dB
    set_cur(uafg_pkg::ENT_FEATURE, uafg_pkg::CS_VOLUME, 8'd0, uafg_pkg::LEN_VOLUME,
            32'h0000_0001);
    set_cur(uafg_pkg::ENT_FEATURE, uafg_pkg::CS_VOLUME, 8'd0, uafg_pkg::LEN_VOLUME,
            32'h0000_c3ff);
    set_cur(uafg_pkg::ENT_FEATURE, uafg_pkg::CS_VOLUME, 8'd0, uafg_pkg::LEN_VOLUME,
            {16'd0, uafg_pkg::VOL_MAX});
    set_cur(uafg_pkg::ENT_FEATURE, uafg_pkg::CS_VOLUME, 8'd1, uafg_pkg::LEN_VOLUME,
            {16'd0, uafg_pkg::VOL_MAX});
  endtask

  task automatic test_clock();
    set_cur(uafg_pkg::ENT_CLOCK, uafg_pkg::CS_SAM_FREQ, 8'd0, uafg_pkg::LEN_RATE,
            uafg_pkg::SAMPLE_RATE);
    set_cur(uafg_pkg::ENT_CLOCK, uafg_pkg::CS_SAM_FREQ, 8'd1, uafg_pkg::LEN_RATE, 32'd44100);
    get_req(8'd2, uafg_pkg::ENT_CLOCK, uafg_pkg::CS_SAM_FREQ, 8'd0);
  endtask

  task automatic test_rejects();
    send_item(uafg_pkg::OP_SET, mk(8'd0, uafg_pkg::ENT_FEATURE, uafg_pkg::CS_MUTE, 8'd0,
                                   uafg_pkg::LEN_MUTE, 32'd1, 16'd0));
    set_cur(uafg_pkg::ENT_FEATURE, uafg_pkg::CS_MUTE, 8'(CHANNELS), uafg_pkg::LEN_MUTE, 32'd1);
    set_cur(uafg_pkg::ENT_FEATURE, uafg_pkg::CS_MUTE, 8'd1, uafg_pkg::LEN_VOLUME, 32'd1);
    get_req(uafg_pkg::REQ_CUR, uafg_pkg::ENT_FEATURE, uafg_pkg::CS_MUTE, 8'hff);
    get_req(uafg_pkg::REQ_CUR, 8'hff, uafg_pkg::CS_MUTE, 8'd0);
    send_item(OP_UNDEF, req_t'({$urandom, $urandom, $urandom}));
  endtask

  task automatic test_output_stall();
    fork
      begin
        long_hold <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
      end
      begin
        for (int i = 0; i < 24; i++) play(16'($urandom));
      end
    join
  endtask

  task automatic test_random(input int count);
    logic [1:0] op;
    req_t r;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      random_item(op, r);
      send_item(op, r);
    end
  endtask

  task automatic test_steady_stream();
    logic [1:0] op;
    req_t r;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    for (int i = 0; i < 150; i++) begin
      random_item(op, r);
      send_item(op, r);
    end
  endtask

  // receiver: random idle bursts plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_idle_left <= 0;
    end else if (long_hold) begin
      m_tready <= 1'b0;
    end else if (sink_idle_left != 0) begin
      m_tready <= 1'b0;
      sink_idle_left <= sink_idle_left - 1;
    end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
      m_tready <= 1'b0;
      sink_idle_left <= $urandom_range(0, 14);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = reply_t'(m_tdata[48:0]);
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply %h", m_tdata);
      end else begin
        want = reply_q.pop_front();
        if (got.accepted !== want.accepted || got.read_value !== want.read_value ||
            got.sample_out !== want.sample_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply mismatch: expected acc %0d rd %h smp %h, got acc %0d rd %h smp %h",
                     want.accepted, want.read_value, want.sample_out,
                     got.accepted, got.read_value, got.sample_out);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      mute_state[i] = 1'b0;
      volume_state[i] = 16'd0;
    end
    gain_state = {16'd0, uafg_pkg::UNITY_GAIN};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_mute();
    wait_drained();
    test_volume();
    wait_drained();
    test_clock();
    test_rejects();
    wait_drained();
    test_output_stall();
    wait_drained();
    test_random(1350);
    wait_drained();
    test_steady_stream();
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/uafg_pkg.sv
sv/uafg_alu.sv
sv/usb_audio_feature_unit_gain.sv
test/testbench.sv
